FILE: hw/rtl/ift_pkg.sv
// ----------------------------------------------------------------------------
// Image fit transform package
// Shared constants, the scale mode type, the pipeline carry record and the
// fixed point helper functions.
// ----------------------------------------------------------------------------
package ift_pkg;

    // Number format and port geometry.
    localparam int COORD_WIDTH    = 32;
    localparam int FRACTION_BITS  = 16;
    localparam int IMG_WIDTH      = 16;
    localparam int APB_ADDR_WIDTH = 5;
    localparam int APB_DATA_WIDTH = 32;
    localparam int REG_IDX_WIDTH  = APB_ADDR_WIDTH - 2;
    localparam int SAT_WIDTH      = 2 * COORD_WIDTH + 2;

    // Cycles from an accepted transaction to its result strobe.
    localparam int PIPE_LATENCY   = COORD_WIDTH + 9;

    // Register map, as word indexes.
    localparam logic [REG_IDX_WIDTH-1:0] REG_SCALE_MODE = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_SCALE_X    = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_SKEW_X     = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_TRANS_X    = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_SKEW_Y     = 3'd4;
    localparam logic [REG_IDX_WIDTH-1:0] REG_SCALE_Y    = 3'd5;
    localparam logic [REG_IDX_WIDTH-1:0] REG_TRANS_Y    = 3'd6;

    // Fixed point 1.0 and the saturation bounds in the wide format.
    localparam logic signed [COORD_WIDTH-1:0] FIX_ONE =
        COORD_WIDTH'(64'(1) << FRACTION_BITS);
    localparam logic signed [SAT_WIDTH-1:0] SAT_HI =
        {{(SAT_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SAT_WIDTH-1:0] SAT_LO =
        {{(SAT_WIDTH-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_NONE      = 2'd0,
        MODE_STRETCH   = 2'd1,
        MODE_LETTERBOX = 2'd2,
        MODE_ZOOM      = 2'd3
    } t_mode;

    // Per-transaction values that travel alongside the pipeline.
    typedef struct packed {
        logic                          ok;
        logic signed [COORD_WIDTH-1:0] bl;
        logic signed [COORD_WIDTH-1:0] bt;
        logic        [COORD_WIDTH:0]   bw;
        logic        [COORD_WIDTH:0]   bh;
        logic        [COORD_WIDTH:0]   tw;
        logic        [COORD_WIDTH:0]   th;
        logic signed [COORD_WIDTH:0]   ntl;
        logic signed [COORD_WIDTH:0]   ntt;
    } t_carry;

    // Clamp a wide signed value to the coordinate range.
    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [SAT_WIDTH-1:0] v
    );
        if (v > SAT_HI) begin
            return SAT_HI[COORD_WIDTH-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[COORD_WIDTH-1:0];
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] smin(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] smax(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: hw/rtl/image_fit_transform.sv
// ----------------------------------------------------------------------------
// Image fit transform
// Maps the image rectangle through the configured affine matrix, bounds the
// mapped corners and returns a stretch, letterbox or zoom fit transform.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration is written over the APB port (registers at 4*index) while
//   no transaction is in flight. A transaction is taken on every rising edge
//   with start high; busy is always low, so one transaction per cycle is
//   accepted with no gaps.
//   Each result is presented for exactly one cycle with o_valid high.
//   The pipeline is built around the restoring divider: COORD_WIDTH
//   stages, one quotient bit per stage after the first, plus five setup
//   stages in front (corner products, saturation, corner sums, bounding
//   box, extents) and four behind it (scale select, offset products,
//   saturation, final sum).
//   Throughput is one result per cycle at any fill level.
//   The receiver cannot stall; results leave in acceptance order.
//   Synchronous reset clears all valid bits, so transactions in flight are
//   dropped, and loads the registers with mode none and the identity matrix.
// ----------------------------------------------------------------------------
module image_fit_transform (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic signed [ift_pkg::COORD_WIDTH-1:0]      i_bounds_left,
    input  logic signed [ift_pkg::COORD_WIDTH-1:0]      i_bounds_top,
    input  logic signed [ift_pkg::COORD_WIDTH-1:0]      i_bounds_right,
    input  logic signed [ift_pkg::COORD_WIDTH-1:0]      i_bounds_bottom,
    input  logic        [ift_pkg::IMG_WIDTH-1:0]        i_image_width,
    input  logic        [ift_pkg::IMG_WIDTH-1:0]        i_image_height,
    output logic                                        o_valid,
    output logic signed [ift_pkg::COORD_WIDTH-1:0]      o_fit_scale_x,
    output logic signed [ift_pkg::COORD_WIDTH-1:0]      o_fit_scale_y,
    output logic signed [ift_pkg::COORD_WIDTH-1:0]      o_fit_offset_x,
    output logic signed [ift_pkg::COORD_WIDTH-1:0]      o_fit_offset_y,
    output logic                                        o_fell_back,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic        [ift_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic        [ift_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic        [ift_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                        pready
);
    import ift_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int PW = CW + IMG_WIDTH + 1;
    localparam int SH = CW - 1 - FB;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_mode                 r_mode;
    logic signed [CW-1:0]  r_scale_x, r_skew_x, r_trans_x;
    logic signed [CW-1:0]  r_skew_y, r_scale_y, r_trans_y;
    logic [REG_IDX_WIDTH-1:0] reg_idx;
    logic                  cfg_wr;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_idx = paddr[APB_ADDR_WIDTH-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    // Register writes; an index past the map is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NONE;
            r_scale_x <= FIX_ONE;
            r_skew_x  <= '0;
            r_trans_x <= '0;
            r_skew_y  <= '0;
            r_scale_y <= FIX_ONE;
            r_trans_y <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SCALE_MODE: r_mode    <= t_mode'(pwdata[1:0]);
                REG_SCALE_X:    r_scale_x <= pwdata[CW-1:0];
                REG_SKEW_X:     r_skew_x  <= pwdata[CW-1:0];
                REG_TRANS_X:    r_trans_x <= pwdata[CW-1:0];
                REG_SKEW_Y:     r_skew_y  <= pwdata[CW-1:0];
                REG_SCALE_Y:    r_scale_y <= pwdata[CW-1:0];
                REG_TRANS_Y:    r_trans_y <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // Register read mux.
    always_comb begin
        unique case (reg_idx)
            REG_SCALE_MODE: prdata = APB_DATA_WIDTH'(r_mode);
            REG_SCALE_X:    prdata = APB_DATA_WIDTH'(r_scale_x);
            REG_SKEW_X:     prdata = APB_DATA_WIDTH'(r_skew_x);
            REG_TRANS_X:    prdata = APB_DATA_WIDTH'(r_trans_x);
            REG_SKEW_Y:     prdata = APB_DATA_WIDTH'(r_skew_y);
            REG_SCALE_Y:    prdata = APB_DATA_WIDTH'(r_scale_y);
            REG_TRANS_Y:    prdata = APB_DATA_WIDTH'(r_trans_y);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 1: corner products, target extents and early checks
    // ------------------------------------------------------------------
    logic                 r1_v;
    t_carry               r1_c, n1_c;
    logic signed [PW-1:0] r1_ax, r1_bx, r1_ay, r1_by;
    logic signed [PW-1:0] w_s, h_s;

    assign w_s = PW'($signed({1'b0, i_image_width}));
    assign h_s = PW'($signed({1'b0, i_image_height}));

    always_comb begin
        n1_c     = '0;
        n1_c.ok  = (r_mode != MODE_NONE) && (i_bounds_left < i_bounds_right) &&
                   (i_bounds_top < i_bounds_bottom) &&
                   (i_image_width != '0) && (i_image_height != '0);
        n1_c.bl  = i_bounds_left;
        n1_c.bt  = i_bounds_top;
        n1_c.bw  = (CW+1)'(i_bounds_right) - (CW+1)'(i_bounds_left);
        n1_c.bh  = (CW+1)'(i_bounds_bottom) - (CW+1)'(i_bounds_top);
    end

    always_ff @(posedge i_clk) begin
        r1_c  <= n1_c;
        r1_ax <= PW'(r_scale_x) * w_s;
        r1_bx <= PW'(r_skew_x) * h_s;
        r1_ay <= PW'(r_skew_y) * w_s;
        r1_by <= PW'(r_scale_y) * h_s;
    end

    // ------------------------------------------------------------------
    // Stage 2: saturate the corner products
    // ------------------------------------------------------------------
    logic                 r2_v;
    t_carry               r2_c;
    logic signed [CW-1:0] r2_ax, r2_bx, r2_ay, r2_by;

    always_ff @(posedge i_clk) begin
        r2_c  <= r1_c;
        r2_ax <= sat_coord(SAT_WIDTH'(r1_ax));
        r2_bx <= sat_coord(SAT_WIDTH'(r1_bx));
        r2_ay <= sat_coord(SAT_WIDTH'(r1_ay));
        r2_by <= sat_coord(SAT_WIDTH'(r1_by));
    end

    // ------------------------------------------------------------------
    // Stage 3: mapped corners (origin, right, bottom, far corner)
    // ------------------------------------------------------------------
    logic                 r3_v;
    t_carry               r3_c;
    logic signed [CW-1:0] r3_x [4];
    logic signed [CW-1:0] r3_y [4];

    always_ff @(posedge i_clk) begin
        r3_c    <= r2_c;
        r3_x[0] <= r_trans_x;
        r3_x[1] <= sat_coord(SAT_WIDTH'(r2_ax) + SAT_WIDTH'(r_trans_x));
        r3_x[2] <= sat_coord(SAT_WIDTH'(r2_bx) + SAT_WIDTH'(r_trans_x));
        r3_x[3] <= sat_coord(SAT_WIDTH'(r2_ax) + SAT_WIDTH'(r2_bx) +
                             SAT_WIDTH'(r_trans_x));
        r3_y[0] <= r_trans_y;
        r3_y[1] <= sat_coord(SAT_WIDTH'(r2_ay) + SAT_WIDTH'(r_trans_y));
        r3_y[2] <= sat_coord(SAT_WIDTH'(r2_by) + SAT_WIDTH'(r_trans_y));
        r3_y[3] <= sat_coord(SAT_WIDTH'(r2_ay) + SAT_WIDTH'(r2_by) +
                             SAT_WIDTH'(r_trans_y));
    end

    // ------------------------------------------------------------------
    // Stage 4: bounding box of the mapped corners
    // ------------------------------------------------------------------
    logic                 r4_v;
    t_carry               r4_c;
    logic signed [CW-1:0] r4_tl, r4_tr, r4_tt, r4_tb;

    always_ff @(posedge i_clk) begin
        r4_c  <= r3_c;
        r4_tl <= smin(smin(r3_x[0], r3_x[1]), smin(r3_x[2], r3_x[3]));
        r4_tr <= smax(smax(r3_x[0], r3_x[1]), smax(r3_x[2], r3_x[3]));
        r4_tt <= smin(smin(r3_y[0], r3_y[1]), smin(r3_y[2], r3_y[3]));
        r4_tb <= smax(smax(r3_y[0], r3_y[1]), smax(r3_y[2], r3_y[3]));
    end

    // ------------------------------------------------------------------
    // Stage 5: box extents, negated origin and the empty box check
    // ------------------------------------------------------------------
    logic   r5_v;
    t_carry r5_c, n5_c;

    always_comb begin
        n5_c     = r4_c;
        n5_c.ok  = r4_c.ok && (r4_tl < r4_tr) && (r4_tt < r4_tb);
        n5_c.tw  = (CW+1)'(r4_tr) - (CW+1)'(r4_tl);
        n5_c.th  = (CW+1)'(r4_tb) - (CW+1)'(r4_tt);
        n5_c.ntl = -(CW+1)'(r4_tl);
        n5_c.ntt = -(CW+1)'(r4_tt);
    end

    always_ff @(posedge i_clk) begin
        r5_c <= n5_c;
    end

    // ------------------------------------------------------------------
    // Ratio dividers: (extent << FB) / box, one quotient bit per stage.
    // Stage 0 detects overflow and loads the partial remainder.
    // ------------------------------------------------------------------
    logic                 r_dv_v    [CW];
    t_carry               r_dv_c    [CW];
    logic [CW+1:0]        r_dv_remx [CW];
    logic [CW+1:0]        r_dv_remy [CW];
    logic [CW-2:0]        r_dv_qx   [CW];
    logic [CW-2:0]        r_dv_qy   [CW];
    logic                 r_dv_ovx  [CW];
    logic                 r_dv_ovy  [CW];

    always_ff @(posedge i_clk) begin
        r_dv_c[0]    <= r5_c;
        r_dv_remx[0] <= (CW+2)'(r5_c.bw >> SH);
        r_dv_remy[0] <= (CW+2)'(r5_c.bh >> SH);
        r_dv_ovx[0]  <= (r5_c.bw >> SH) >= r5_c.tw;
        r_dv_ovy[0]  <= (r5_c.bh >> SH) >= r5_c.th;
        r_dv_qx[0]   <= '0;
        r_dv_qy[0]   <= '0;
    end

    for (genvar k = 1; k < CW; k++) begin : g_div
        localparam int BI = CW - 1 - k;
        logic          nbx, nby, gex, gey;
        logic [CW+1:0] tx, ty;
        logic [CW-2:0] qnx, qny;

        // Next dividend bit; the fraction bits below FB are zero.
        if (BI >= FB) begin : g_bit
            assign nbx = r_dv_c[k-1].bw[BI-FB];
            assign nby = r_dv_c[k-1].bh[BI-FB];
        end else begin : g_zero
            assign nbx = 1'b0;
            assign nby = 1'b0;
        end

        assign tx  = {r_dv_remx[k-1][CW:0], nbx};
        assign ty  = {r_dv_remy[k-1][CW:0], nby};
        assign gex = tx >= (CW+2)'(r_dv_c[k-1].tw);
        assign gey = ty >= (CW+2)'(r_dv_c[k-1].th);

        // Partial quotients with this stage's bit filled in.
        always_comb begin
            qnx     = r_dv_qx[k-1];
            qnx[BI] = gex;
            qny     = r_dv_qy[k-1];
            qny[BI] = gey;
        end

        always_ff @(posedge i_clk) begin
            r_dv_c[k]       <= r_dv_c[k-1];
            r_dv_ovx[k]     <= r_dv_ovx[k-1];
            r_dv_ovy[k]     <= r_dv_ovy[k-1];
            r_dv_remx[k]    <= gex ? tx - (CW+2)'(r_dv_c[k-1].tw) : tx;
            r_dv_remy[k]    <= gey ? ty - (CW+2)'(r_dv_c[k-1].th) : ty;
            r_dv_qx[k]      <= qnx;
            r_dv_qy[k]      <= qny;
        end
    end

    // ------------------------------------------------------------------
    // Post stage 1: saturate the ratios and pick the scale per mode
    // ------------------------------------------------------------------
    logic          r6_v;
    t_carry        r6_c;
    logic [CW-2:0] r6_sx, r6_sy, n6_sx, n6_sy;
    logic [CW-2:0] qxu, qyu;

    always_comb begin
        qxu = r_dv_ovx[CW-1] ? '1 : r_dv_qx[CW-1];
        qyu = r_dv_ovy[CW-1] ? '1 : r_dv_qy[CW-1];
        case (r_mode)
            MODE_STRETCH: begin
                n6_sx = qxu;
                n6_sy = qyu;
            end
            MODE_LETTERBOX: begin
                n6_sx = (qxu < qyu) ? qxu : qyu;
                n6_sy = n6_sx;
            end
            default: begin
                n6_sx = (qxu > qyu) ? qxu : qyu;
                n6_sy = n6_sx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r6_c  <= r_dv_c[CW-1];
        r6_sx <= n6_sx;
        r6_sy <= n6_sy;
    end

    // ------------------------------------------------------------------
    // Post stage 2: origin shift and scaled box products
    // ------------------------------------------------------------------
    logic                   r7_v;
    t_carry                 r7_c;
    logic [CW-2:0]          r7_sx, r7_sy;
    logic signed [2*CW:0]   r7_px, r7_py;
    logic [2*CW-1:0]        r7_wx, r7_wy;

    always_ff @(posedge i_clk) begin
        r7_c  <= r6_c;
        r7_sx <= r6_sx;
        r7_sy <= r6_sy;
        r7_px <= (2*CW+1)'($signed({1'b0, r6_sx})) * (2*CW+1)'(r6_c.ntl);
        r7_py <= (2*CW+1)'($signed({1'b0, r6_sy})) * (2*CW+1)'(r6_c.ntt);
        r7_wx <= (2*CW)'(r6_sx) * (2*CW)'(r6_c.tw);
        r7_wy <= (2*CW)'(r6_sy) * (2*CW)'(r6_c.th);
    end

    // ------------------------------------------------------------------
    // Post stage 3: floor and saturate products, halve the leftover space
    // ------------------------------------------------------------------
    logic                 r8_v;
    t_carry               r8_c;
    logic [CW-2:0]        r8_sx, r8_sy;
    logic signed [CW-1:0] r8_mx, r8_my;
    logic signed [CW:0]   r8_hx, r8_hy;
    logic [2*CW-1:0]      wshx, wshy;
    logic [CW-2:0]        wsatx, wsaty;
    logic signed [CW+1:0] dx, dy;

    always_comb begin
        wshx  = r7_wx >> FB;
        wshy  = r7_wy >> FB;
        wsatx = (wshx > (2*CW)'({(CW-1){1'b1}})) ? '1 : wshx[CW-2:0];
        wsaty = (wshy > (2*CW)'({(CW-1){1'b1}})) ? '1 : wshy[CW-2:0];
        dx    = $signed({1'b0, r7_c.bw}) - $signed({3'b000, wsatx});
        dy    = $signed({1'b0, r7_c.bh}) - $signed({3'b000, wsaty});
    end

    always_ff @(posedge i_clk) begin
        r8_c  <= r7_c;
        r8_sx <= r7_sx;
        r8_sy <= r7_sy;
        r8_mx <= sat_coord(SAT_WIDTH'(r7_px >>> FB));
        r8_my <= sat_coord(SAT_WIDTH'(r7_py >>> FB));
        r8_hx <= dx[CW+1:1];
        r8_hy <= dy[CW+1:1];
    end

    // ------------------------------------------------------------------
    // Output stage: final offsets, or the identity on fallback
    // ------------------------------------------------------------------
    logic signed [CW:0]   halfx, halfy;
    logic signed [CW-1:0] offx, offy;

    always_comb begin
        halfx = (r_mode == MODE_STRETCH) ? '0 : r8_hx;
        halfy = (r_mode == MODE_STRETCH) ? '0 : r8_hy;
        offx  = sat_coord(SAT_WIDTH'(r8_mx) + SAT_WIDTH'(r8_c.bl) + SAT_WIDTH'(halfx));
        offy  = sat_coord(SAT_WIDTH'(r8_my) + SAT_WIDTH'(r8_c.bt) + SAT_WIDTH'(halfy));
    end

    always_ff @(posedge i_clk) begin
        if (r8_c.ok) begin
            o_fit_scale_x  <= $signed({1'b0, r8_sx});
            o_fit_scale_y  <= $signed({1'b0, r8_sy});
            o_fit_offset_x <= offx;
            o_fit_offset_y <= offy;
            o_fell_back    <= 1'b0;
        end else begin
            o_fit_scale_x  <= FIX_ONE;
            o_fit_scale_y  <= FIX_ONE;
            o_fit_offset_x <= '0;
            o_fit_offset_y <= '0;
            o_fell_back    <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Valid bits for every stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            r8_v    <= 1'b0;
            o_valid <= 1'b0;
            for (int i = 0; i < CW; i++) begin
                r_dv_v[i] <= 1'b0;
            end
        end else begin
            r1_v      <= start && !busy;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r4_v      <= r3_v;
            r5_v      <= r4_v;
            r_dv_v[0] <= r5_v;
            for (int i = 1; i < CW; i++) begin
                r_dv_v[i] <= r_dv_v[i-1];
            end
            r6_v      <= r_dv_v[CW-1];
            r7_v      <= r6_v;
            r8_v      <= r7_v;
            o_valid   <= r8_v;
        end
    end

`ifndef SYNTH
    // Every result strobe traces back to a transaction accepted earlier.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result strobe without an accepted transaction");

    // A real fit never yields a negative scale.
    a_scale_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_fell_back |-> !o_fit_scale_x[CW-1] && !o_fit_scale_y[CW-1])
        else $error("negative fit scale");

    // Letterbox and zoom scale both axes alike.
    a_uniform: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_fell_back && (r_mode != MODE_STRETCH) |->
        o_fit_scale_x == o_fit_scale_y)
        else $error("uneven scale in letterbox or zoom mode");

    // Mode none always falls back to the identity.
    a_mode_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_mode == MODE_NONE) |-> o_fell_back)
        else $error("mode none produced a fit");
`endif

endmodule
